FILE: rtl/salct_pkg.sv
// Package: shared types, constants and helpers of the cache tag store.
`default_nettype none
package salct_pkg;

    localparam int DEF_MAX_SETS   = 256;
    localparam int DEF_MAX_WAYS   = 8;
    localparam int DEF_ADDR_WIDTH = 32;

    localparam int FIELD_ADDR_W = 32;
    localparam int OPCODE_W     = 2;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 4;
    localparam int WAY_OUT_W    = 3;
    localparam int COUNT_W      = 32;
    localparam int OUT_DATA_W   = 136;

    localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RST_OFFSET_BITS = 4'd5;
    localparam logic [CFG_DATA_W-1:0] RST_INDEX_BITS  = 4'd6;
    localparam logic [CFG_DATA_W-1:0] RST_WAYS_IN_USE = 4'd4;

    localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd1;

    typedef struct packed {
        logic clear;
        logic load;
        logic lookup;
    } ctl_cmd_t;

    typedef struct packed {
        logic clear_last;
    } ctl_sts_t;

    function automatic int floor_log2(input int v);
        int r;
        int x;
        r = 0;
        x = v;
        while (x > 1) begin
            x = x / 2;
            r = r + 1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/salct_ctrl.sv
// Controller: sequences the clearing pass and each access through read, lookup and send.
`default_nettype none
module salct_ctrl
    import salct_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    input  wire ctl_sts_t sts,
    output ctl_cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_LOOK  = 4'b0100,
        ST_SEND  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid) state_next = ST_LOOK;
            end
            ST_LOOK: begin
                cmd.lookup = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND: begin
                m_tvalid = 1'b1;
                if (m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({s_tready, m_tvalid, cmd.clear, cmd.lookup}))
        else $error("controller drives more than one phase");
    a_load_to_look: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> cmd.lookup)
        else $error("accepted transfer not looked up next cycle");
    a_look_to_send: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.lookup |=> (m_tvalid && !s_tready))
        else $error("lookup not followed by result");
`endif

endmodule
`default_nettype wire

FILE: rtl/salct_dp.sv
// Datapath: config registers, set memories, hit/victim selection, LRU update, counters.
`default_nettype none
module salct_dp
    import salct_pkg::*;
#(
    parameter int MAX_SETS   = DEF_MAX_SETS,
    parameter int MAX_WAYS   = DEF_MAX_WAYS,
    parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [FIELD_ADDR_W-1:0] in_addr,
    input  wire logic [OPCODE_W-1:0]     in_op,
    input  wire ctl_cmd_t                cmd,
    output ctl_sts_t                     sts,
    output logic [OUT_DATA_W-1:0]        result
);

    localparam int SETB = floor_log2(MAX_SETS);
    localparam int SW   = (SETB > 0) ? SETB : 1;
    localparam int WW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int AW   = ADDR_WIDTH;
    // sets an index can reach
    localparam int ROWS = 1 << SETB;

    logic [CFG_DATA_W-1:0] off_reg, ib_reg, nw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg <= RST_OFFSET_BITS;
            ib_reg  <= RST_INDEX_BITS;
            nw_reg  <= RST_WAYS_IN_USE;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_OFFSET_BITS: off_reg <= cfg_data;
                CFG_INDEX_BITS:  ib_reg  <= cfg_data;
                CFG_WAYS_IN_USE: nw_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamped configuration
    logic [CFG_DATA_W-1:0] ib_eff;
    logic [4:0]            nw_eff;
    assign ib_eff = (ib_reg > CFG_DATA_W'(SETB)) ? CFG_DATA_W'(SETB) : ib_reg;
    always_comb begin
        if (nw_reg == '0) nw_eff = 5'd1;
        else if (32'(nw_reg) > 32'(MAX_WAYS)) nw_eff = 5'(MAX_WAYS);
        else nw_eff = 5'(nw_reg);
    end

    // address split
    logic [AW-1:0] addr_ext, shifted, tag_in;
    logic [SW-1:0] set_in;
    assign addr_ext = AW'(in_addr);
    assign shifted  = addr_ext >> off_reg;
    assign set_in   = shifted[SW-1:0] & ~({SW{1'b1}} << ib_eff);
    assign tag_in   = shifted >> ib_eff;

    logic [SW-1:0] set_reg, clr_reg;
    logic [AW-1:0] tag_reg;
    logic          wr_reg;

    // set memories, one row per set
    logic [MAX_WAYS-1:0][AW-1:0] tag_mem   [ROWS];
    logic [MAX_WAYS-1:0]         valid_mem [ROWS];
    logic [MAX_WAYS-1:0]         dirty_mem [ROWS];
    logic [MAX_WAYS-1:0][WW-1:0] rank_mem  [ROWS];

    logic [MAX_WAYS-1:0][AW-1:0] tag_rd, tag_wr;
    logic [MAX_WAYS-1:0]         valid_rd, valid_wr, dirty_rd, dirty_wr;
    logic [MAX_WAYS-1:0][WW-1:0] rank_rd, rank_wr, rank_init;

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) rank_init[w] = WW'(w);
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            valid_mem[clr_reg] <= '0;
            dirty_mem[clr_reg] <= '0;
            rank_mem[clr_reg]  <= rank_init;
        end else if (cmd.lookup) begin
            tag_mem[set_reg]   <= tag_wr;
            valid_mem[set_reg] <= valid_wr;
            dirty_mem[set_reg] <= dirty_wr;
            rank_mem[set_reg]  <= rank_wr;
        end
        if (cmd.load) begin
            tag_rd   <= tag_mem[set_in];
            valid_rd <= valid_mem[set_in];
            dirty_rd <= dirty_mem[set_in];
            rank_rd  <= rank_mem[set_in];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            set_reg <= set_in;
            tag_reg <= tag_in;
            wr_reg  <= (in_op == OP_WRITE);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clear) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end
    assign sts.clear_last = (32'(clr_reg) == ROWS - 1);

    // lookup and replacement
    logic          hit, inv_found, wb;
    logic [WW-1:0] hit_way, inv_way, lru_way, place;
    logic [WW-1:0] oldest, old_rank;

    always_comb begin
        hit       = 1'b0;
        inv_found = 1'b0;
        hit_way   = '0;
        inv_way   = '0;
        lru_way   = '0;
        oldest    = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (5'(w) < nw_eff) begin
                if (!hit && valid_rd[w] && tag_rd[w] == tag_reg) begin
                    hit     = 1'b1;
                    hit_way = WW'(w);
                end
                if (!inv_found && !valid_rd[w]) begin
                    inv_found = 1'b1;
                    inv_way   = WW'(w);
                end
                if (rank_rd[w] >= oldest) begin
                    oldest  = rank_rd[w];
                    lru_way = WW'(w);
                end
            end
        end
        if (hit) place = hit_way;
        else if (inv_found) place = inv_way;
        else place = lru_way;
        wb = !hit && !inv_found && dirty_rd[lru_way];
    end

    always_comb begin
        tag_wr   = tag_rd;
        valid_wr = valid_rd;
        dirty_wr = dirty_rd;
        old_rank = rank_rd[place];
        if (hit) begin
            if (wr_reg) dirty_wr[place] = 1'b1;
        end else begin
            valid_wr[place] = 1'b1;
            dirty_wr[place] = wr_reg;
            tag_wr[place]   = tag_reg;
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WW'(w) == place) rank_wr[w] = '0;
            else if (rank_rd[w] < old_rank) rank_wr[w] = rank_rd[w] + 1'b1;
            else rank_wr[w] = rank_rd[w];
        end
    end

    logic [COUNT_W-1:0] acc_reg, hit_cnt_reg, miss_reg, wb_cnt_reg;
    logic               hit_reg, wb_reg;
    logic [WW-1:0]      way_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            hit_cnt_reg <= '0;
            miss_reg    <= '0;
            wb_cnt_reg  <= '0;
        end else if (cmd.lookup) begin
            acc_reg     <= acc_reg + 1'b1;
            hit_cnt_reg <= hit_cnt_reg + COUNT_W'(hit);
            miss_reg    <= miss_reg + COUNT_W'(!hit);
            wb_cnt_reg  <= wb_cnt_reg + COUNT_W'(wb);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            hit_reg <= hit;
            wb_reg  <= wb;
            way_reg <= place;
        end
    end

    assign result = {3'b000, wb_cnt_reg, miss_reg, hit_cnt_reg, acc_reg,
                     WAY_OUT_W'(way_reg), wb_reg, hit_reg};

endmodule
`default_nettype wire

FILE: rtl/set_assoc_lru_cache_tags.sv
// Top level: tag store of a set-associative write-back cache with LRU replacement.
`default_nettype none
// After reset the block clears its valid, dirty and recency state one set per
// cycle over every set an index can reach (MAX_SETS sets when MAX_SETS is a
// power of two), and accepts no access until that pass ends.
// Each access then passes through set memory read, lookup and update, and
// result, and the result may wait for m_tready; the next access is taken once
// the result transfer completes. Reading and rewriting one set-memory row per
// access is what keeps accesses from overlapping.
module set_assoc_lru_cache_tags
    import salct_pkg::*;
#(
    parameter int MAX_SETS   = DEF_MAX_SETS,
    parameter int MAX_WAYS   = DEF_MAX_WAYS,
    parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [FIELD_ADDR_W-1:0] s_tdata,  // address
    input  wire logic [OPCODE_W-1:0]     s_tuser,  // opcode
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // hit, writeback, way[2:0], access_total, hit_total, miss_total,
    // writeback_total, zero pad
    output logic [OUT_DATA_W-1:0]        m_tdata
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    salct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    salct_dp #(
        .MAX_SETS   (MAX_SETS),
        .MAX_WAYS   (MAX_WAYS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_addr   (s_tdata),
        .in_op     (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .result    (m_tdata)
    );

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// Testbench for the set-associative LRU cache tag store: directed table plus random accesses.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import salct_pkg::*;

    localparam int N_SETS = DEF_MAX_SETS;
    localparam int N_WAYS = DEF_MAX_WAYS;
    localparam int N_RANDOM = 1730;
    localparam int STALL_LIMIT = 20000;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_FETCH = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_ODD   = 2'd3;

    // last member sits in the lowest bits, matching m_tdata
    typedef struct packed {
        logic [31:0] writebacks;
        logic [31:0] misses;
        logic [31:0] hits;
        logic [31:0] accesses;
        logic [2:0]  way;
        logic        writeback;
        logic        hit;
    } lookup_t;

    typedef struct {
        logic [31:0]  addr;
        logic [1:0]   op;
        bit           known;
        lookup_t      res;
    } access_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [FIELD_ADDR_W-1:0] s_tdata = '0;
    logic [OPCODE_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    set_assoc_lru_cache_tags dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow tag store
    bit          sh_valid [N_SETS*N_WAYS];
    bit          sh_dirty [N_SETS*N_WAYS];
    logic [31:0] sh_tag   [N_SETS*N_WAYS];
    logic [2:0]  sh_rank  [N_SETS*N_WAYS];
    logic [31:0] cnt_acc, cnt_hit, cnt_miss, cnt_wb;
    logic [3:0]  cur_offset, cur_index, cur_ways;

    lookup_t pending_results[$];
    int errors = 0;
    int n_sent = 0, n_recv = 0, n_hits = 0, n_wbs = 0;
    int idle_cycles = 0;
    bit rx_idle_mode = 1'b1;
    bit hold_off = 1'b0;

    function automatic lookup_t cache_access(logic [31:0] addr, logic [1:0] op);
        lookup_t r;
        int ib, nw, set_no, base, place, oldest;
        logic [31:0] tag;
        bit hit, found;
        ib = (cur_index > 8) ? 8 : cur_index;
        nw = (cur_ways == 0) ? 1 : ((cur_ways > N_WAYS) ? N_WAYS : cur_ways);
        set_no = (addr >> cur_offset) & ((1 << ib) - 1);
        tag = 32'(64'(addr) >> (cur_offset + ib));
        base = set_no * N_WAYS;
        hit = 0; found = 0; place = 0; oldest = 0;
        r = '0;
        cnt_acc++;
        for (int w = 0; w < nw && !hit; w++)
            if (sh_valid[base+w] && sh_tag[base+w] == tag) begin
                hit = 1; place = w;
            end
        if (hit) begin
            cnt_hit++;
            if (op == OP_WRITE) sh_dirty[base+place] = 1;
        end else begin
            cnt_miss++;
            for (int w = 0; w < nw && !found; w++)
                if (!sh_valid[base+w]) begin
                    found = 1; place = w;
                end
            if (!found) begin
                for (int w = 0; w < nw; w++)
                    if (sh_rank[base+w] >= oldest) begin
                        oldest = sh_rank[base+w]; place = w;
                    end
                if (sh_dirty[base+place]) begin
                    r.writeback = 1; cnt_wb++;
                end
            end
            sh_valid[base+place] = 1;
            sh_dirty[base+place] = (op == OP_WRITE);
            sh_tag[base+place] = tag;
        end
        // age every way younger than the touched one
        oldest = sh_rank[base+place];
        for (int w = 0; w < N_WAYS; w++)
            if (sh_rank[base+w] < oldest) sh_rank[base+w]++;
        sh_rank[base+place] = 0;
        r.hit = hit; r.way = 3'(place);
        r.accesses = cnt_acc; r.hits = cnt_hit; r.misses = cnt_miss; r.writebacks = cnt_wb;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH result %0d %s: got %0h expected %0h", n_recv, what, got, want);
        errors++;
    endtask

    // input side; tvalid stays up between back-to-back transfers
    task automatic send_access(logic [31:0] addr, logic [1:0] op, bit known, lookup_t res);
        lookup_t pred;
        pred = cache_access(addr, op);
        if (known && pred != res) begin
            $display("MISMATCH directed row %0d: table disagrees with predictor", n_sent);
            errors++;
        end
        if (rx_idle_mode)
            while ($urandom_range(99) < 31) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        s_tdata <= addr;
        s_tuser <= op;
        s_tvalid <= 1'b1;
        pending_results.push_back(known ? res : pred);
        do @(posedge aclk); while (!s_tready);
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [3:0] val);
        cfg_wr_en <= 1'b1; cfg_addr <= idx; cfg_data <= val;
        @(negedge aclk);
        if (idx == CFG_OFFSET_BITS) cur_offset = val;
        else if (idx == CFG_INDEX_BITS) cur_index = val;
        else cur_ways = val;
    endtask

    task automatic set_geometry(logic [3:0] ob, logic [3:0] ib, logic [3:0] nw);
        drain();
        write_reg(CFG_OFFSET_BITS, ob);
        write_reg(CFG_INDEX_BITS, ib);
        write_reg(CFG_WAYS_IN_USE, nw);
        cfg_wr_en <= 1'b0;
    endtask

    // result side
    always @(negedge aclk) begin
        if (hold_off || (rx_idle_mode && $urandom_range(99) < 31)) m_tready <= 1'b0;
        else m_tready <= 1'b1;
    end

    always @(posedge aclk) begin
        lookup_t got, want;
        if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready))) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles > STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = lookup_t'(m_tdata[132:0]);
            if (pending_results.size() == 0) begin
                $display("MISMATCH unexpected result %0d", n_recv);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.hit != want.hit)
                    report_mismatch("hit", 32'(got.hit), 32'(want.hit));
                if (got.writeback != want.writeback)
                    report_mismatch("writeback", 32'(got.writeback), 32'(want.writeback));
                if (got.way != want.way)
                    report_mismatch("way", 32'(got.way), 32'(want.way));
                if (got.accesses != want.accesses)
                    report_mismatch("access_total", got.accesses, want.accesses);
                if (got.hits != want.hits) report_mismatch("hit_total", got.hits, want.hits);
                if (got.misses != want.misses)
                    report_mismatch("miss_total", got.misses, want.misses);
                if (got.writebacks != want.writebacks)
                    report_mismatch("writeback_total", got.writebacks, want.writebacks);
                if (got.hit) n_hits++;
                if (got.writeback) n_wbs++;
            end
            n_recv++;
        end
    end

    // random address drawn from a small pool of tags so sets fill and evict
    function automatic logic [31:0] pick_addr();
        logic [31:0] a;
        int ib;
        ib = (cur_index > 8) ? 8 : cur_index;
        a = $urandom();
        if ($urandom_range(9) < 8) begin
            // tag limited to a few values, set limited to a few sets
            a = a & ((32'd1 << cur_offset) - 1);
            a = a | (32'($urandom_range(3)) << cur_offset);
            if (cur_offset + ib < 32)
                a = a | (32'($urandom_range(11)) << (cur_offset + ib));
        end
        return a;
    endfunction

    access_row_t directed[$];

    initial begin
        lookup_t r;
        logic [3:0] ob, ib, nw;
        cur_offset = RST_OFFSET_BITS; cur_index = RST_INDEX_BITS; cur_ways = RST_WAYS_IN_USE;
        cnt_acc = 0; cnt_hit = 0; cnt_miss = 0; cnt_wb = 0;
        for (int i = 0; i < N_SETS*N_WAYS; i++) begin
            sh_valid[i] = 0; sh_dirty[i] = 0; sh_tag[i] = '0; sh_rank[i] = 3'(i % N_WAYS);
        end
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: first access after reset is a cold miss into way 0
        r = '0; r.accesses = 1; r.misses = 1;
        directed.push_back('{32'h0000_0000, OP_READ, 1, r});
        r = '0; r.hit = 1; r.accesses = 2; r.hits = 1; r.misses = 1;
        directed.push_back('{32'h0000_001F, OP_WRITE, 1, r});
        directed.push_back('{32'hFFFF_FFFF, OP_FETCH, 0, '0});
        directed.push_back('{32'hFFFF_FFE0, OP_ODD, 0, '0});
        // fill set 0 with five tags: forces an eviction of the dirty line
        for (int t = 1; t < 6; t++)
            directed.push_back('{32'(t) << 11, (t % 2) ? OP_WRITE : OP_READ, 0, '0});
        directed.push_back('{32'h0000_0000, OP_READ, 0, '0});
        directed.push_back('{32'h0000_0800, OP_READ, 0, '0});
        directed.push_back('{32'hAAAA_AAAA, OP_WRITE, 0, '0});
        directed.push_back('{32'h5555_5555, OP_WRITE, 0, '0});
        foreach (directed[i])
            send_access(directed[i].addr, directed[i].op, directed[i].known, directed[i].res);

        // extremes: offset 12 and 0, oversize and zero index, zero and oversize ways
        set_geometry(4'd12, 4'd15, 4'd0);
        for (int i = 0; i < 6; i++) send_access(pick_addr(), 2'(i % 4), 0, '0);
        set_geometry(4'd0, 4'd0, 4'd15);
        for (int i = 0; i < 10; i++) send_access(32'(i) & 32'h7, OP_WRITE, 0, '0);
        send_access(32'h0000_0008, OP_READ, 0, '0);

        // receiver holds off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(negedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 20; i++) send_access(pick_addr(), 2'($urandom_range(3)), 0, '0);
        join

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin ob = 4'd5; ib = 4'd6; nw = 4'd4; end
                1: begin ob = 4'd0; ib = 4'd0; nw = 4'd1; end
                2: begin ob = 4'd12; ib = 4'd8; nw = 4'd8; end
                3: begin ob = 4'd3; ib = 4'd2; nw = 4'd2; end
                default: begin
                    ob = 4'($urandom_range(12)); ib = 4'($urandom_range(15));
                    nw = 4'($urandom_range(15));
                end
            endcase
            set_geometry(ob, ib, nw);
            rx_idle_mode = (ph != 2);
            for (int i = 0; i < N_RANDOM / 8; i++)
                send_access(pick_addr(), 2'($urandom_range(3)), 0, '0);
        end
        rx_idle_mode = 1'b1;
        drain();

        $display("Covered %0d accesses over 11 geometries: %0d hits, %0d writebacks",
                 n_sent, n_hits, n_wbs);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: files.f
rtl/salct_pkg.sv
rtl/salct_ctrl.sv
rtl/salct_dp.sv
rtl/set_assoc_lru_cache_tags.sv
verif/tb_top.sv
